// ===== hw/rtl/prbb_pkg.sv =====
`timescale 1ns / 1ps

package prbb_pkg;

  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned NUM_TAP  = 4;
  localparam int unsigned TGT_W    = 22;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned AREA_W   = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [PIX_W-1:0] HALF_MASK  = 32'h7f7f7f7f;
  localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hFF000000;

  // corner order: top left, top right, bottom left, bottom right
  localparam int unsigned TAP_TL = 0;
  localparam int unsigned TAP_TR = 1;
  localparam int unsigned TAP_BL = 2;
  localparam int unsigned TAP_BR = 3;

  typedef enum logic [1:0] {
    MODE_BILINEAR = 2'd0,
    MODE_DIRECT   = 2'd1,
    MODE_FWD_MAX  = 2'd2,
    MODE_AVERAGE  = 2'd3
  } mode_e;

  typedef logic [NUM_TAP-1:0][CH_W-1:0] tap_vec_t;

  typedef struct packed {
    mode_e mode;
    logic  blend;
    logic  bil_ok;
    logic  in_rng;
    logic  ent_rng;
  } ctl_t;

  // floor(a * b / 255), exact for all 8-bit operands
  function automatic logic [CH_W-1:0] scale_mul(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    logic [2*CH_W-1:0] prod;
    logic [2*CH_W:0]   x;
    logic [2*CH_W:0]   q;
    prod = a * b;
    x    = {1'b0, prod} + 17'd1;
    q    = (x + (x >> CH_W)) >> CH_W;
    return q[CH_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/prbb_weight.sv =====
`timescale 1ns / 1ps

module prbb_weight #(
  parameter int unsigned FRACTION_BITS = 5
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [FRACTION_BITS-1:0]     frac_y_i,
  input  logic [FRACTION_BITS-1:0]     frac_x_i,
  output prbb_pkg::tap_vec_t           weight_o
);
  import prbb_pkg::*;

  localparam int unsigned SHIFT = CH_W - FRACTION_BITS;

  logic [CH_W-1:0] sx, sy, isx, isy;
  tap_vec_t        weight_d, weight_q;

  assign sx  = CH_W'(frac_x_i) << SHIFT;
  assign sy  = CH_W'(frac_y_i) << SHIFT;
  assign isx = 8'd255 - sx;
  assign isy = 8'd255 - sy;

  always_comb begin
    weight_d         = '0;
    weight_d[TAP_TL] = scale_mul(isx, isy);
    weight_d[TAP_TR] = scale_mul(sx, isy);
    weight_d[TAP_BL] = scale_mul(isx, sy);
    weight_d[TAP_BR] = scale_mul(sx, sy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
    end
  end

  assign weight_o = weight_q;

endmodule

// ===== hw/rtl/prbb_lane.sv =====
`timescale 1ns / 1ps

module prbb_lane (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  prbb_pkg::tap_vec_t         chan_i,
  input  prbb_pkg::tap_vec_t         weight_i,
  output logic [prbb_pkg::CH_W-1:0]  sum_o
);
  import prbb_pkg::*;

  logic [CH_W-1:0] sum_d, sum_q;

  // sum wraps to 8 bits
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NUM_TAP; k++) begin
      sum_d = sum_d + scale_mul(chan_i[k], weight_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== hw/rtl/prbb_merge.sv =====
`timescale 1ns / 1ps

module prbb_merge (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  prbb_pkg::ctl_t                            ctl_i,
  input  logic [prbb_pkg::NUM_CH-1:0][prbb_pkg::CH_W-1:0] sum_i,
  input  logic [prbb_pkg::PIX_W-1:0]                top_left_i,
  input  logic [prbb_pkg::PIX_W-1:0]                own_i,
  input  logic [prbb_pkg::PIX_W-1:0]                dest_i,
  output logic [prbb_pkg::PIX_W-1:0]                pixel_o,
  output logic                                      write_enable_o
);
  import prbb_pkg::*;

  function automatic logic [PIX_W-1:0] avg_px(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return ((a >> 1) & HALF_MASK) + ((b >> 1) & HALF_MASK);
  endfunction

  function automatic logic [PIX_W-1:0] max_px(logic [PIX_W-1:0] keep,
                                              logic [PIX_W-1:0] other);
    logic [PIX_W-1:0] r;
    r = keep & ALPHA_MASK;
    for (int c = 0; c < NUM_CH; c++) begin
      r[c*CH_W +: CH_W] = (keep[c*CH_W +: CH_W] > other[c*CH_W +: CH_W]) ?
                          keep[c*CH_W +: CH_W] : other[c*CH_W +: CH_W];
    end
    return r;
  endfunction

  logic [PIX_W-1:0] bil, pull, pixel_d, pixel_q;
  logic             we_d, we_q;

  assign bil = {top_left_i[PIX_W-1 -: CH_W], sum_i[2], sum_i[1], sum_i[0]};

  always_comb begin
    pull    = '0;
    pixel_d = '0;
    we_d    = 1'b1;
    case (ctl_i.mode)
      MODE_BILINEAR: begin
        if (ctl_i.bil_ok) begin
          pull = bil;
        end else if (ctl_i.in_rng) begin
          pull = top_left_i;
        end
        pixel_d = ctl_i.blend ? avg_px(own_i, pull) : pull;
      end
      MODE_DIRECT: begin
        if (ctl_i.ent_rng) begin
          pull = top_left_i;
        end
        pixel_d = ctl_i.blend ? avg_px(own_i, pull) : pull;
      end
      MODE_FWD_MAX: begin
        we_d    = ctl_i.in_rng;
        pixel_d = ctl_i.in_rng ? max_px(own_i, dest_i) : '0;
      end
      MODE_AVERAGE: begin
        pixel_d = avg_px(dest_i, own_i);
      end
      default: begin
        pixel_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
      we_q    <= we_d;
    end
  end

  assign pixel_o        = pixel_q;
  assign write_enable_o = we_q;

endmodule

// ===== hw/rtl/pixel_remap_bilinear_blender_core.sv =====
`timescale 1ns / 1ps

// Map-driven pixel resampler. One word in per clock, one word out per clock when the output
// is not stalled; an accepted word passes weight stage, three channel lanes and merge/output
// register to output valid. The whole pipeline advances whenever the output register is
// empty or being taken, so throughput is one word per cycle under no backpressure. Frame
// size registers feed a registered width*height product, so an item accepted in the cycle
// after a size write already sees the new area. Config writes are always accepted.

module pixel_remap_bilinear_blender_core #(
  parameter int unsigned INDEX_BITS    = 22,
  parameter int unsigned FRACTION_BITS = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // map_entry, pixel_top_left, pixel_top_right, pixel_bottom_left,
  // pixel_bottom_right, own_pixel, dest_pixel
  input  logic [223:0]                    s_axis_tdata,
  // mode
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_out, target_index, zero pad
  output logic [55:0]                     m_axis_tdata,
  // write_enable
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prbb_pkg::DIM_W-1:0]      cfg_data_i
);
  import prbb_pkg::*;

  localparam int unsigned CMP_W = AREA_W + 1;

  logic             blend_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [AREA_W-1:0] area_q;

  logic en;
  logic v1_q, v2_q, vo_q;

  logic [PIX_W-1:0] entry_in;
  logic [63:0]      entry_ext;
  logic [NUM_TAP-1:0][PIX_W-1:0] pix_in;
  logic [PIX_W-1:0] own_in, dest_in;

  logic [PIX_W-1:0]              entry1_q;
  logic [NUM_TAP-1:0][PIX_W-1:0] pix1_q;
  logic [PIX_W-1:0]              own1_q, dest1_q;
  mode_e                         mode1_q;
  tap_vec_t                      weight1;

  logic [INDEX_BITS-1:0] idx1;
  logic [63:0]           idx_ext;
  logic [TGT_W-1:0]      tgt2_q, tgt_o_q;
  ctl_t                  ctl2_d, ctl2_q;
  logic [PIX_W-1:0]      tl2_q, own2_q, dest2_q;
  logic [NUM_CH-1:0][CH_W-1:0] lane_sum;

  logic [PIX_W-1:0] pixel_out;
  logic             we_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q  <= 1'b0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLEND_ENABLE: blend_q  <= cfg_data_i[0];
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= width_q * height_q;
  end

  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  assign entry_in  = s_axis_tdata[31:0];
  assign entry_ext = 64'(entry_in);
  assign own_in    = s_axis_tdata[191:160];
  assign dest_in   = s_axis_tdata[223:192];
  always_comb begin
    for (int k = 0; k < NUM_TAP; k++) begin
      pix_in[k] = s_axis_tdata[(k+1)*PIX_W +: PIX_W];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      entry1_q <= entry_in;
      pix1_q   <= pix_in;
      own1_q   <= own_in;
      dest1_q  <= dest_in;
      mode1_q  <= mode_e'(s_axis_tuser);
    end
  end

  prbb_weight #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_weight (
    .clk_i   (clk_i),
    .en_i    (en),
    .frac_y_i(entry_ext[INDEX_BITS +: FRACTION_BITS]),
    .frac_x_i(entry_ext[INDEX_BITS + FRACTION_BITS +: FRACTION_BITS]),
    .weight_o(weight1)
  );

  // stage 2
  assign idx1    = entry1_q[INDEX_BITS-1:0];
  assign idx_ext = 64'(idx1);

  always_comb begin
    ctl2_d.mode    = mode1_q;
    ctl2_d.blend   = blend_q;
    ctl2_d.bil_ok  = (CMP_W'(idx1) + CMP_W'(width_q) + CMP_W'(1)) < CMP_W'(area_q);
    ctl2_d.in_rng  = CMP_W'(idx1) < CMP_W'(area_q);
    ctl2_d.ent_rng = entry1_q < PIX_W'(area_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl2_q  <= ctl2_d;
      tl2_q   <= pix1_q[TAP_TL];
      own2_q  <= own1_q;
      dest2_q <= dest1_q;
      tgt2_q  <= idx_ext[TGT_W-1:0];
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    tap_vec_t chan;
    always_comb begin
      for (int k = 0; k < NUM_TAP; k++) begin
        chan[k] = pix1_q[k][c*CH_W +: CH_W];
      end
    end
    prbb_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .chan_i  (chan),
      .weight_i(weight1),
      .sum_o   (lane_sum[c])
    );
  end

  // stage 3
  prbb_merge u_merge (
    .clk_i         (clk_i),
    .en_i          (en),
    .ctl_i         (ctl2_q),
    .sum_i         (lane_sum),
    .top_left_i    (tl2_q),
    .own_i         (own2_q),
    .dest_i        (dest2_q),
    .pixel_o       (pixel_out),
    .write_enable_o(we_out)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tgt_o_q <= tgt2_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {2'b00, tgt_o_q, pixel_out};
  assign m_axis_tuser  = we_out;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en) |=> m_axis_tvalid)
    else $error("word lost between lanes and output");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted word not captured");

  a_no_write_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == '0))
    else $error("suppressed write carries nonzero pixel");

endmodule
